FILE: sv/isbn_pkg.sv
// shared types, character codes and small arithmetic helpers for the isbn check digit validator
// no dependencies; used by isbn_check_digit_validator
`default_nettype none

package isbn_pkg;

  // transfer payloads
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [1:0] form;
  } out_t;

  // form codes
  localparam logic [1:0] FORM_NONE     = 2'd0;
  localparam logic [1:0] FORM_TEN      = 2'd1;
  localparam logic [1:0] FORM_THIRTEEN = 2'd2;

  // character codes
  localparam logic [7:0] CH_HYPHEN = 8'd45;
  localparam logic [7:0] CH_X      = 8'd88;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  // lengths and counts
  localparam logic [4:0] PREFIX_LEN       = 5'd5;
  localparam logic [4:0] LEN_TEN_M1       = 5'd17;  // char count before the 18th char
  localparam logic [4:0] LEN_THIRTEEN_M1  = 5'd21;  // char count before the 22nd char
  localparam logic [4:0] CHAR_MAX         = 5'd31;
  localparam logic [2:0] HYPHEN_MAX       = 3'd7;
  localparam logic [3:0] DIGIT_MAX        = 4'd15;
  localparam logic [2:0] HYPHENS_TEN      = 3'd3;
  localparam logic [2:0] HYPHENS_THIRTEEN = 3'd4;
  localparam logic [3:0] SYMS_TEN         = 4'd10;
  localparam logic [3:0] SYMS_THIRTEEN    = 4'd13;
  localparam logic [3:0] X_VALUE          = 4'd10;
  localparam logic [1:0] HEAVY_WEIGHT     = 2'd3;

  // expected prefix "ISBN "
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'd73;
      3'd1:    c = 8'd83;
      3'd2:    c = 8'd66;
      3'd3:    c = 8'd78;
      3'd4:    c = 8'd32;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // reduce a value below 176 modulo 11 by conditional subtracts
  function automatic logic [3:0] mod_eleven(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd88) r = r - 8'd88;
    if (r >= 8'd44) r = r - 8'd44;
    if (r >= 8'd22) r = r - 8'd22;
    if (r >= 8'd11) r = r - 8'd11;
    return r[3:0];
  endfunction

  // reduce a value below 40 modulo 10
  function automatic logic [3:0] mod_ten(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd20) r = r - 6'd20;
    if (r >= 6'd10) r = r - 6'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/isbn_check_digit_validator.sv
// isbn-10 / isbn-13 check digit validator, one character per transfer
// depends on isbn_pkg for payload types, character codes and modulo helpers
// the last character passes the input register, then the result register
// throughput: one character per cycle; input register feeds the running state,
// and a result held by the downstream side stalls the input until it is taken
// reset: rst_n synchronous active low clears handshake flags and running state
`default_nettype none

module isbn_check_digit_validator (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire isbn_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output isbn_pkg::out_t     out_data
);

  // input register
  logic           s1_valid_r;
  isbn_pkg::in_t  s1_data_r;

  // running state
  logic [4:0] char_count_r,   char_count_nxt;
  logic       prefix_match_r, prefix_match_nxt;
  logic [2:0] hyphen_count_r, hyphen_count_nxt;
  logic [3:0] digit_count_r,  digit_count_nxt;
  logic [3:0] sum_mod_eleven_r, sum_mod_eleven_nxt;
  logic [3:0] sum_mod_ten_r,  sum_mod_ten_nxt;
  logic       bad_char_r,     bad_char_nxt;
  logic       x_misplaced_r,  x_misplaced_nxt;
  logic       x_seen_r,       x_seen_nxt;

  // result register
  logic           out_valid_r;
  isbn_pkg::out_t out_data_r, out_data_nxt;

  logic advance;
  logic s1_fire;
  logic in_fire;

  // pipeline moves when the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-character state update and result evaluation
  always_comb begin
    logic [7:0] c;
    logic       is_digit;
    logic       is_x;
    logic [3:0] val;
    logic [3:0] w10;
    logic [1:0] w13;
    logic [7:0] sum11_raw;
    logic [5:0] sum10_raw;
    logic [1:0] form;
    logic       ok;

    c        = s1_data_r.ch;
    is_digit = (c >= isbn_pkg::CH_ZERO) && (c <= isbn_pkg::CH_NINE);
    is_x     = (c == isbn_pkg::CH_X);
    val      = is_x ? isbn_pkg::X_VALUE : 4'(c - isbn_pkg::CH_ZERO);
    w10      = (digit_count_r < isbn_pkg::SYMS_TEN) ?
               4'(isbn_pkg::SYMS_TEN - digit_count_r) : 4'd0;
    w13      = (digit_count_r < isbn_pkg::SYMS_THIRTEEN) ?
               (digit_count_r[0] ? isbn_pkg::HEAVY_WEIGHT : 2'd1) : 2'd0;
    sum11_raw = 8'(sum_mod_eleven_r) + 8'(val) * 8'(w10);
    sum10_raw = 6'(sum_mod_ten_r) + 6'(val) * 6'(w13);

    char_count_nxt     = char_count_r;
    prefix_match_nxt   = prefix_match_r;
    hyphen_count_nxt   = hyphen_count_r;
    digit_count_nxt    = digit_count_r;
    sum_mod_eleven_nxt = sum_mod_eleven_r;
    sum_mod_ten_nxt    = sum_mod_ten_r;
    bad_char_nxt       = bad_char_r;
    x_misplaced_nxt    = x_misplaced_r;
    x_seen_nxt         = x_seen_r;

    // classify the character
    if (char_count_r < isbn_pkg::PREFIX_LEN) begin
      if (c != isbn_pkg::prefix_char(char_count_r[2:0])) prefix_match_nxt = 1'b0;
    end else if (c == isbn_pkg::CH_HYPHEN) begin
      if (hyphen_count_r < isbn_pkg::HYPHEN_MAX) hyphen_count_nxt = hyphen_count_r + 3'd1;
    end else if (is_digit || is_x) begin
      sum_mod_eleven_nxt = isbn_pkg::mod_eleven(sum11_raw);
      if (is_x) begin
        x_seen_nxt = 1'b1;
        if (digit_count_r != 4'(isbn_pkg::SYMS_TEN - 4'd1)) x_misplaced_nxt = 1'b1;
      end else begin
        sum_mod_ten_nxt = isbn_pkg::mod_ten(sum10_raw);
      end
      if (digit_count_r < isbn_pkg::DIGIT_MAX) digit_count_nxt = digit_count_r + 4'd1;
    end else begin
      bad_char_nxt = 1'b1;
    end

    if (char_count_r < isbn_pkg::CHAR_MAX) char_count_nxt = char_count_r + 5'd1;

    // length decides the form
    if (char_count_r == isbn_pkg::LEN_TEN_M1) begin
      form = isbn_pkg::FORM_TEN;
    end else if (char_count_r == isbn_pkg::LEN_THIRTEEN_M1) begin
      form = isbn_pkg::FORM_THIRTEEN;
    end else begin
      form = isbn_pkg::FORM_NONE;
    end

    ok = 1'b0;
    if (prefix_match_nxt && !bad_char_nxt && !x_misplaced_nxt) begin
      if (form == isbn_pkg::FORM_TEN && hyphen_count_nxt == isbn_pkg::HYPHENS_TEN &&
          digit_count_nxt == isbn_pkg::SYMS_TEN && sum_mod_eleven_nxt == 4'd0) begin
        ok = 1'b1;
      end
      if (form == isbn_pkg::FORM_THIRTEEN &&
          hyphen_count_nxt == isbn_pkg::HYPHENS_THIRTEEN &&
          digit_count_nxt == isbn_pkg::SYMS_THIRTEEN && sum_mod_ten_nxt == 4'd0 &&
          !x_seen_nxt) begin
        ok = 1'b1;
      end
    end

    out_data_nxt.valid_res = ok;
    out_data_nxt.form      = form;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_fire) s1_data_r <= in_data;
  end

  // running state, back to reset values after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_data_r.last)) begin
      char_count_r     <= 5'd0;
      prefix_match_r   <= 1'b1;
      hyphen_count_r   <= 3'd0;
      digit_count_r    <= 4'd0;
      sum_mod_eleven_r <= 4'd0;
      sum_mod_ten_r    <= 4'd0;
      bad_char_r       <= 1'b0;
      x_misplaced_r    <= 1'b0;
      x_seen_r         <= 1'b0;
    end else if (s1_fire) begin
      char_count_r     <= char_count_nxt;
      prefix_match_r   <= prefix_match_nxt;
      hyphen_count_r   <= hyphen_count_nxt;
      digit_count_r    <= digit_count_nxt;
      sum_mod_eleven_r <= sum_mod_eleven_nxt;
      sum_mod_ten_r    <= sum_mod_ten_nxt;
      bad_char_r       <= bad_char_nxt;
      x_misplaced_r    <= x_misplaced_nxt;
      x_seen_r         <= x_seen_nxt;
    end
  end

  // result register, loaded only by the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_data_r.last;
    end
    if (s1_fire && s1_data_r.last) out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // a passing result always names a form
  a_valid_has_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.valid_res || out_data_r.form != isbn_pkg::FORM_NONE))
    else $error("valid result without a form");

  // the last character leaves the running state at reset values
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_data_r.last) |=>
      (char_count_r == 5'd0 && prefix_match_r && digit_count_r == 4'd0 &&
       hyphen_count_r == 3'd0 && !bad_char_r && !x_seen_r))
    else $error("state not cleared after last character");

  // a result only follows a last character leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_data_r.last))
    else $error("result without a last character");

  // input side is never blocked while the result side is free
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) |-> in_ready)
    else $error("input stalled with free result register");
`endif

endmodule

`default_nettype wire
